// ===== hw/rtl/lprmq_pkg.sv =====
package lprmq_pkg;

   // Field widths of one input beat and one result beat
   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;
   localparam int STAT_W = 3;
   localparam int FREE_W = 11;

   // Default geometry
   localparam int RING_BYTES_DEF  = 1024;
   localparam int MAX_MESSAGE_DEF = 64;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);

   // Command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_POP_BYTE  = 3'd0;
   localparam logic [STAT_W-1:0] STAT_PUSH_OK   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_PUSH_DROP = 3'd2;
   localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 3'd3;
   localparam logic [STAT_W-1:0] STAT_POP_BIG   = 3'd4;

   // One classified command, as queued between front and back
   typedef struct packed {
      logic              is_pop;
      logic [DATA_W-1:0] data;
      logic              last;
      logic [LEN_W-1:0]  capacity;
   } item_type;

endpackage

// ===== hw/rtl/lprmq_front.sv =====
module lprmq_front
   import lprmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [DATA_W-1:0] req_data_in,
   input  logic              req_last_in,
   input  logic [LEN_W-1:0]  req_capacity,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_take
);

   item_type           q_mem_ff [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       count_ff, count_in;
   logic               accept;
   logic               drain;
   item_type           new_item;

   assign busy    = (count_ff == (QAW+1)'(QDEPTH));
   assign accept  = start && !busy;
   assign q_valid = (count_ff != '0);
   assign drain   = q_valid && q_take;
   assign q_item  = q_mem_ff[rd_ptr_ff];

   // classify the beat on the way in
   always_comb begin
      new_item.is_pop   = (req_cmd == CMD_POP);
      new_item.data     = req_data_in;
      new_item.last     = req_last_in && (req_cmd == CMD_PUSH);
      new_item.capacity = req_capacity;
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = drain  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !drain) begin
         count_in = count_ff + (QAW+1)'(1);
      end else if (drain && !accept) begin
         count_in = count_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hw/rtl/lprmq_back.sv =====
module lprmq_back
   import lprmq_pkg::*;
#(
   parameter int RING_BYTES  = RING_BYTES_DEF,
   parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_take,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_data_out,
   output logic              rsp_last_out,
   output logic [STAT_W-1:0] rsp_status,
   output logic [LEN_W-1:0]  rsp_msg_length,
   output logic [FREE_W-1:0] rsp_free_bytes
);

   localparam int AW = $clog2(RING_BYTES);
   localparam int UW = AW + 1;
   localparam int CW = UW + 9;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_HDR    = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + b;
      if (sum >= (AW+1)'(RING_BYTES)) begin
         sum = sum - (AW+1)'(RING_BYTES);
      end
      return sum[AW-1:0];
   endfunction

   logic [DATA_W-1:0] ring_mem [RING_BYTES];
   logic [DATA_W-1:0] rd_data_ff;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [UW-1:0]     used_ff, used_in;
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic              pdrop_ff, pdrop_in;
   logic [LEN_W-1:0]  cap_ff, cap_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;

   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0]     first_pos;
   logic [AW:0]       hdr_step;
   logic              stream_end;

   assign hdr_step   = (AW+1)'(CW'(rd_data_ff) + CW'(1));
   assign first_pos  = wrap_add(head_ff, (AW+1)'(1));
   assign stream_end = ((idx_ff + LEN_W'(1)) == len_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      wptr_in       = wptr_ff;
      plen_in       = plen_ff;
      pdrop_in      = pdrop_ff;
      cap_in        = cap_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = STAT_POP_EMPTY;
      rsp_len_in    = '0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = wptr_ff;
      wr_data       = q_item.data;
      q_take        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (!q_item.is_pop) begin
                  // store the byte unless the record is already lost
                  if (!pdrop_ff) begin
                     if ((plen_ff >= LEN_W'(MAX_MESSAGE)) ||
                         (CW'(used_ff) + CW'(plen_ff) + CW'(2) > CW'(RING_BYTES))) begin
                        pdrop_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        plen_in = plen_ff + LEN_W'(1);
                        wptr_in = wrap_add(wptr_ff, (AW+1)'(1));
                     end
                  end
                  if (q_item.last) begin
                     if (pdrop_in) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_PUSH_DROP;
                        pdrop_in      = 1'b0;
                        plen_in       = '0;
                        wptr_in       = wrap_add(tail_ff, (AW+1)'(1));
                     end else begin
                        state_in = S_COMMIT;
                     end
                  end
               end else begin
                  if (used_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_POP_EMPTY;
                  end else begin
                     cap_in   = q_item.capacity;
                     state_in = S_HDR;
                  end
               end
            end
         end
         S_COMMIT: begin
            // back-fill the header; the write pointer already sits past the record
            wr_en         = 1'b1;
            wr_addr       = tail_ff;
            wr_data       = DATA_W'(plen_ff);
            tail_in       = wptr_ff;
            wptr_in       = wrap_add(wptr_ff, (AW+1)'(1));
            used_in       = UW'(CW'(used_ff) + CW'(plen_ff) + CW'(1));
            plen_in       = '0;
            pdrop_in      = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_PUSH_OK;
            rsp_len_in    = plen_ff;
            state_in      = S_IDLE;
         end
         S_HDR: begin
            if ((rd_data_ff == '0) || (rd_data_ff > DATA_W'(MAX_MESSAGE)) ||
                (CW'(rd_data_ff) + CW'(1) > CW'(used_ff))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_POP_EMPTY;
               state_in      = S_IDLE;
            end else if (rd_data_ff > {1'b0, cap_ff}) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_POP_BIG;
               rsp_len_in    = rd_data_ff[LEN_W-1:0];
               state_in      = S_IDLE;
            end else begin
               head_in  = wrap_add(head_ff, hdr_step);
               used_in  = used_ff - UW'(hdr_step);
               rd_addr  = first_pos;
               pos_in   = wrap_add(first_pos, (AW+1)'(1));
               idx_in   = '0;
               len_in   = rd_data_ff[LEN_W-1:0];
               state_in = S_STREAM;
            end
         end
         S_STREAM: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = rd_data_ff;
            rsp_last_in   = stream_end;
            rsp_status_in = STAT_POP_BYTE;
            rsp_len_in    = len_ff;
            rd_addr       = pos_ff;
            pos_in        = wrap_add(pos_ff, (AW+1)'(1));
            idx_in        = idx_ff + LEN_W'(1);
            if (stream_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_free_in = FREE_W'(UW'(RING_BYTES) - used_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         wptr_ff      <= AW'(1);
         plen_ff      <= '0;
         pdrop_ff     <= 1'b0;
         idx_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         wptr_ff      <= wptr_in;
         plen_ff      <= plen_in;
         pdrop_ff     <= pdrop_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff        <= cap_in;
      pos_ff        <= pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_msg_length = rsp_len_ff;
   assign rsp_free_bytes = rsp_free_ff;

endmodule

// ===== hw/rtl/length_prefixed_ring_message_queue.sv =====
// Byte ring holding whole variable-length messages, each stored as a one-byte
// length header followed by its payload, wrapping around the end of the ring.
// Request channel: drive start with req_cmd/req_data_in/req_last_in/req_capacity;
// a beat is taken at a rising edge with start high and busy low. A push beat
// writes one payload byte; the beat flagged last commits the record (status
// push committed) or reports it dropped when it outgrew the free space or the
// maximum message size. A pop beat returns the oldest committed message.
// Result channel: rsp_strobe marks one result beat for exactly one cycle; the
// receiver cannot stall, so every result must be taken as it appears.
// Flow: a beat waits in a two-entry command queue, then the ring engine
// works on it. A plain push writes its payload byte; a committing push also
// back-fills the header (payload write, then header back-fill through the
// single write port) before its result. A pop reads the header from the ring
// memory, checks it, then streams out one payload byte per cycle. Empty pops
// answer at the idle or header check, too-large pops at the header check.
// Reset clears the pointers, the byte count and any partial record; ring
// contents are left as they are and are only read where a commit wrote.
module length_prefixed_ring_message_queue
   import lprmq_pkg::*;
#(
   parameter int RING_BYTES  = RING_BYTES_DEF,
   parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [DATA_W-1:0] req_data_in,
   input  logic              req_last_in,
   input  logic [LEN_W-1:0]  req_capacity,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_data_out,
   output logic              rsp_last_out,
   output logic [STAT_W-1:0] rsp_status,
   output logic [LEN_W-1:0]  rsp_msg_length,
   output logic [FREE_W-1:0] rsp_free_bytes
);

   // queued command between front and back
   logic     q_valid;
   logic     q_take;
   item_type q_item;

   // front: accept and classify beats, hold them until the engine is free
   lprmq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_data_in  (req_data_in),
      .req_last_in  (req_last_in),
      .req_capacity (req_capacity),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_take       (q_take)
   );

   // back: ring memory, pointers and the push/pop sequencer
   lprmq_back #(
      .RING_BYTES  (RING_BYTES),
      .MAX_MESSAGE (MAX_MESSAGE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_take         (q_take),
      .rsp_strobe     (rsp_strobe),
      .rsp_data_out   (rsp_data_out),
      .rsp_last_out   (rsp_last_out),
      .rsp_status     (rsp_status),
      .rsp_msg_length (rsp_msg_length),
      .rsp_free_bytes (rsp_free_bytes)
   );

endmodule
